// ===== hdl/kxd_pkg.sv =====
// Shared types, constants and helpers for the XXTEA keystream XOR decrypt unit.
`timescale 1ns / 1ps

package kxd_pkg;

   localparam int KEY_WORDS_DEF    = 1024;
   localparam int DENSE_WORDS_DEF  = 512;
   localparam int STRIDE_WORDS_DEF = 64;
   localparam int ROUNDS_DEF       = 6;

   localparam logic [31:0] XX_DELTA = 32'h9e37_79b9;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] KEY_WORD0_IDX = 2'd0;
   localparam logic [1:0] KEY_WORD1_IDX = 2'd1;
   localparam logic [1:0] KEY_WORD2_IDX = 2'd2;
   localparam logic [1:0] KEY_WORD3_IDX = 2'd3;

   localparam logic OP_REBUILD = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   typedef struct packed {
      logic        op;
      logic        first_word;
      logic [31:0] data_in;
      logic [2:0]  byte_count;
   } kxd_req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [2:0]  valid_bytes;
   } kxd_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DATA_OUT,
      ST_RB_START,
      ST_RB_MIX,
      ST_RB_WRITE
   } kxd_state_type;

   function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
      logic [31:0] m;
      case (cnt)
         3'd0: m = 32'h0000_0000;
         3'd1: m = 32'h0000_00ff;
         3'd2: m = 32'h0000_ffff;
         3'd3: m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/xxtea_keystream_sparse_xor_decrypt_unit.sv =====
// Top level of the XXTEA keystream XOR decrypt unit: sequencer, counters and register port.
`timescale 1ns / 1ps

// A data transaction is accepted in ST_IDLE and its result is registered in ST_DATA_OUT
// once the result register is free; no new data word is taken before that, but the result
// register lets a new transaction in while the previous result waits. A rebuild runs ROUNDS
// passes over the KEY_WORDS-entry keystream memory through one shared mix unit (a start step
// per round, a mix and a write step per word), with req_ready low throughout. Until the
// first rebuild, data pass through unchanged. Key registers sit at byte addresses 0, 4, 8
// and 12 and are to be written only while idle, a rule the block itself does not enforce.

module xxtea_keystream_sparse_xor_decrypt_unit import kxd_pkg::*; #(
   parameter int KEY_WORDS    = KEY_WORDS_DEF,
   parameter int DENSE_WORDS  = DENSE_WORDS_DEF,
   parameter int STRIDE_WORDS = STRIDE_WORDS_DEF,
   parameter int ROUNDS       = ROUNDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kxd_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kxd_rsp_type           rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int DW = (DENSE_WORDS > 1) ? $clog2(DENSE_WORDS) : 1;
   localparam int SW = (STRIDE_WORDS > 1) ? $clog2(STRIDE_WORDS) : 1;
   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_WORDS - 1);
   localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

   kxd_state_type state_ff, state_in;

   logic [31:0] key_word0_ff, key_word1_ff, key_word2_ff, key_word3_ff;
   logic        csr_write;

   logic          key_ready_ff, key_ready_in;
   logic [DW-1:0] dense_ff, dense_in;
   logic [SW-1:0] stride_ff, stride_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          sparse_ff, sparse_in;

   kxd_req_type req_ff;
   logic        keyed_ff, keyed_in;
   logic        accept;

   logic        rsp_valid_ff, rsp_valid_in;
   kxd_rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] step_ff, step_in;
   logic [RW-1:0] round_ff, round_in;
   logic [31:0]   sum_ff, sum_in;
   logic [31:0]   z_ff, z_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   y_ff, y_in;

   logic          ram_we;
   logic [31:0]   ram_rdata;
   logic [31:0]   new_word;
   logic [31:0]   mix_key;
   logic [1:0]    kidx;
   logic [31:0]   mix_result;
   logic          mix_en;

   logic          first;
   logic [DW-1:0] dense_cur;
   logic [SW-1:0] stride_cur;
   logic [AW-1:0] ptr_cur;
   logic          sparse_cur;
   logic          keyed;
   logic [AW-1:0] step_next;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word0_ff <= '0;
         key_word1_ff <= '0;
         key_word2_ff <= '0;
         key_word3_ff <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            KEY_WORD0_IDX: key_word0_ff <= pwdata;
            KEY_WORD1_IDX: key_word1_ff <= pwdata;
            KEY_WORD2_IDX: key_word2_ff <= pwdata;
            default:       key_word3_ff <= pwdata;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         KEY_WORD0_IDX: prdata = key_word0_ff;
         KEY_WORD1_IDX: prdata = key_word1_ff;
         KEY_WORD2_IDX: prdata = key_word2_ff;
         default:       prdata = key_word3_ff;
      endcase
   end

   // Buffer position for the incoming data word
   always_comb begin
      first      = req_payload.first_word;
      dense_cur  = first ? '0 : dense_ff;
      stride_cur = first ? '0 : stride_ff;
      ptr_cur    = first ? '0 : ptr_ff;
      sparse_cur = first ? 1'b0 : sparse_ff;
      keyed      = !sparse_cur || (stride_cur == '0);
   end

   // Mix unit inputs
   assign kidx = 2'(step_ff) ^ sum_ff[3:2];

   always_comb begin
      case (kidx)
         KEY_WORD0_IDX: mix_key = key_word0_ff;
         KEY_WORD1_IDX: mix_key = key_word1_ff;
         KEY_WORD2_IDX: mix_key = key_word2_ff;
         default:       mix_key = key_word3_ff;
      endcase
   end

   // Unwritten words read as zero in the first round; with a two-word table, word 0 is
   // written in the cycle it would be read, so it comes from z
   assign y_in     = (round_ff == '0 && step_ff != LAST_ADDR) ? 32'h0 :
                     (LAST_ADDR == AW'(1) && step_ff == LAST_ADDR) ? z_ff : ram_rdata;
   assign mix_en   = (state_ff == ST_RB_MIX);
   assign new_word = cur_ff + mix_result;
   assign ram_we   = (state_ff == ST_RB_WRITE);
   assign step_next = step_ff + AW'(1);
   assign accept    = req_valid && req_ready;

   kxd_mix u_mix (
      .clock  (clock),
      .enable (mix_en),
      .y      (y_in),
      .z      (z_ff),
      .sum    (sum_ff),
      .key    (mix_key),
      .result (mix_result)
   );

   kxd_ram #(
      .DEPTH (KEY_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (step_ff),
      .wdata (new_word),
      .raddr (rd_addr_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      key_ready_in = key_ready_ff;
      dense_in     = dense_ff;
      stride_in    = stride_ff;
      ptr_in       = ptr_ff;
      sparse_in    = sparse_ff;
      keyed_in     = keyed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_addr_in   = rd_addr_ff;
      step_in      = step_ff;
      round_in     = round_ff;
      sum_in       = sum_ff;
      z_in         = z_ff;
      cur_in       = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_payload.op == OP_REBUILD) begin
                  round_in = '0;
                  sum_in   = '0;
                  z_in     = '0;
                  cur_in   = '0;
                  state_in = ST_RB_START;
               end else begin
                  rd_addr_in = ptr_cur;
                  keyed_in   = keyed && key_ready_ff;
                  dense_in   = dense_cur;
                  stride_in  = stride_cur;
                  sparse_in  = sparse_cur;
                  ptr_in     = ptr_cur;
                  if (!sparse_cur) begin
                     if (32'(dense_cur) + 32'd1 >= 32'(DENSE_WORDS)) begin
                        dense_in  = '0;
                        stride_in = '0;
                        sparse_in = 1'b1;
                     end else begin
                        dense_in = dense_cur + DW'(1);
                     end
                  end else begin
                     if (32'(stride_cur) + 32'd1 >= 32'(STRIDE_WORDS)) begin
                        stride_in = '0;
                     end else begin
                        stride_in = stride_cur + SW'(1);
                     end
                  end
                  if (keyed) begin
                     ptr_in = (32'(ptr_cur) + 32'd1 >= 32'(KEY_WORDS)) ? '0
                                                                        : ptr_cur + AW'(1);
                  end
                  state_in = ST_DATA_OUT;
               end
            end
         end

         ST_DATA_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.data_out      = req_ff.data_in ^
                  (keyed_ff ? (ram_rdata & byte_mask(req_ff.byte_count)) : 32'h0);
               rsp_in.valid_bytes   = req_ff.byte_count;
               state_in             = ST_IDLE;
            end
         end

         ST_RB_START: begin
            sum_in     = sum_ff + XX_DELTA;
            step_in    = '0;
            rd_addr_in = (LAST_ADDR == '0) ? '0 : AW'(1);
            state_in   = ST_RB_MIX;
         end

         ST_RB_MIX: begin
            state_in = ST_RB_WRITE;
         end

         ST_RB_WRITE: begin
            z_in   = new_word;
            cur_in = y_ff;
            if (step_ff == LAST_ADDR) begin
               if (round_ff == LAST_ROUND) begin
                  key_ready_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  round_in = round_ff + RW'(1);
                  state_in = ST_RB_START;
               end
            end else begin
               step_in    = step_next;
               rd_addr_in = (step_next == LAST_ADDR) ? '0 : step_next + AW'(1);
               state_in   = ST_RB_MIX;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ready_ff <= 1'b0;
         dense_ff     <= '0;
         stride_ff    <= '0;
         ptr_ff       <= '0;
         sparse_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         key_ready_ff <= key_ready_in;
         dense_ff     <= dense_in;
         stride_ff    <= stride_in;
         ptr_ff       <= ptr_in;
         sparse_ff    <= sparse_in;
         rsp_valid_ff <= rsp_valid_in;
         round_ff     <= round_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (mix_en) begin
         y_ff <= y_in;
      end
      keyed_ff   <= keyed_in;
      rsp_ff     <= rsp_in;
      rd_addr_ff <= rd_addr_in;
      sum_ff     <= sum_in;
      z_ff       <= z_in;
      cur_ff     <= cur_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/kxd_ram.sv =====
// Single-port-write, single-port-read keystream memory with registered read data.
`timescale 1ns / 1ps

module kxd_ram import kxd_pkg::*; #(
   parameter int DEPTH = KEY_WORDS_DEF,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [31:0]      wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [31:0]      rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/kxd_mix.sv =====
// XXTEA mixing function as a registered shared arithmetic unit.
`timescale 1ns / 1ps

module kxd_mix import kxd_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] y,
   input  logic [31:0] z,
   input  logic [31:0] sum,
   input  logic [31:0] key,
   output logic [31:0] result
);

   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] result_ff;
   logic [31:0] result_in;

   always_comb begin
      t1 = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      t2 = (sum ^ y) + (key ^ z);
      result_in = t1 ^ t2;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== tb/xxtea_keystream_sparse_xor_decrypt_unit_test.sv =====
// Testbench for the XXTEA keystream XOR decrypt unit: predictor, scoreboard and test tasks.
`timescale 1ns / 1ps

module xxtea_keystream_sparse_xor_decrypt_unit_test;
   import kxd_pkg::*;

   localparam int REBUILD_CYCLES = ROUNDS_DEF * (2 * KEY_WORDS_DEF + 1);
   localparam int QUIET_LIMIT    = 4 * REBUILD_CYCLES + 1000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   kxd_req_type           req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   kxd_rsp_type           rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // predictor state
   logic [31:0] key_reg [4] = '{default: '0};
   logic [31:0] keystream_table [KEY_WORDS_DEF] = '{default: '0};
   logic        pad_ready = 1'b0;
   logic        in_sparse = 1'b0;
   int          dense_done = 0;
   int          stride_pos = 0;
   int          pad_index = 0;

   kxd_rsp_type expected_words [$];
   kxd_rsp_type want;

   int     mismatch_count = 0;
   int     result_count = 0;
   int     data_words = 0;
   int     rebuild_count = 0;
   int     csr_writes = 0;
   int     pad_wraps = 0;
   int     quiet_cycles = 0;
   longint cycle_count = 0;
   longint last_rebuild_cycle = -1000000;
   int     req_gap_pct = 0;
   int     rsp_stall_pct = 0;
   int     stall_left = 0;

   xxtea_keystream_sparse_xor_decrypt_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] xxtea_mix(input logic [31:0] y, input logic [31:0] z,
                                             input logic [31:0] delta_sum,
                                             input logic [1:0] kidx);
      logic [31:0] t1;
      logic [31:0] t2;
      t1 = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      t2 = (delta_sum ^ y) + (key_reg[kidx] ^ z);
      return t1 ^ t2;
   endfunction

   function automatic void regenerate_keystream();
      logic [31:0] delta_sum;
      logic [31:0] y;
      logic [31:0] z;
      logic [1:0]  e;
      foreach (keystream_table[i]) keystream_table[i] = '0;
      delta_sum = '0;
      z = keystream_table[KEY_WORDS_DEF-1];
      for (int r = 0; r < ROUNDS_DEF; r++) begin
         delta_sum = delta_sum + XX_DELTA;
         e = delta_sum[3:2];
         for (int p = 0; p < KEY_WORDS_DEF; p++) begin
            y = keystream_table[(p + 1) % KEY_WORDS_DEF];
            keystream_table[p] = keystream_table[p] + xxtea_mix(y, z, delta_sum, 2'(p) ^ e);
            z = keystream_table[p];
         end
      end
      pad_ready = 1'b1;
   endfunction

   function automatic kxd_rsp_type decrypt_word(input kxd_req_type item);
      kxd_rsp_type res;
      logic [31:0] pad;
      logic [31:0] mask;
      logic        use_pad;
      pad = '0;
      use_pad = 1'b0;
      if (item.first_word) begin
         dense_done = 0;
         stride_pos = 0;
         pad_index = 0;
         in_sparse = 1'b0;
      end
      if (!in_sparse) begin
         use_pad = 1'b1;
         dense_done++;
         if (dense_done >= DENSE_WORDS_DEF) begin
            in_sparse = 1'b1;
            stride_pos = 0;
            dense_done = 0;
         end
      end else begin
         if (stride_pos == 0) use_pad = 1'b1;
         stride_pos++;
         if (stride_pos >= STRIDE_WORDS_DEF) stride_pos = 0;
      end
      if (use_pad) begin
         if (pad_ready) pad = keystream_table[pad_index];
         pad_index++;
         if (pad_index >= KEY_WORDS_DEF) begin
            pad_index = 0;
            pad_wraps++;
         end
      end
      if (item.byte_count >= 3'd4) mask = '1;
      else mask = (32'd1 << (8 * int'(item.byte_count))) - 32'd1;
      res.data_out = item.data_in ^ (pad & mask);
      res.valid_bytes = item.byte_count;
      return res;
   endfunction

   // predict on accepted requests, check accepted results
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         pad_ready = 1'b0;
         in_sparse = 1'b0;
         dense_done = 0;
         stride_pos = 0;
         pad_index = 0;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_payload.op == OP_REBUILD) begin
               regenerate_keystream();
               last_rebuild_cycle = cycle_count;
               rebuild_count++;
            end else begin
               expected_words.push_back(decrypt_word(req_payload));
               data_words++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: unexpected, data_out %h valid_bytes %0d",
                           result_count, rsp_payload.data_out, rsp_payload.valid_bytes);
            end else begin
               want = expected_words.pop_front();
               if (rsp_payload.data_out !== want.data_out ||
                   rsp_payload.valid_bytes !== want.valid_bytes) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: data_out exp %h got %h, valid_bytes exp %0d got %0d",
                              result_count, want.data_out, rsp_payload.data_out,
                              want.valid_bytes, rsp_payload.valid_bytes);
               end
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   always @(posedge clock) begin
      if (stall_left == 0 && rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct)
         stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= 1'b1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic kxd_req_type data_item(input logic starts, input logic [31:0] word,
                                             input logic [2:0] count);
      kxd_req_type t;
      t.op = OP_DATA;
      t.first_word = starts;
      t.data_in = word;
      t.byte_count = count;
      return t;
   endfunction

   function automatic kxd_req_type rebuild_item();
      kxd_req_type t;
      t.op = OP_REBUILD;
      t.first_word = 1'($urandom_range(0, 1));
      t.data_in = $urandom;
      t.byte_count = 3'($urandom_range(0, 7));
      return t;
   endfunction

   function automatic logic [2:0] pick_count();
      if ($urandom_range(0, 9) < 6) return 3'd4;
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic send_item(input kxd_req_type item);
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drains results and lets any rebuild run out before touching the key registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0 ||
             cycle_count - last_rebuild_cycle < REBUILD_CYCLES + 8)
         @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         key_reg[idx] = value;
         csr_writes++;
      end else if (prdata !== key_reg[idx]) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("key register %0d readback: exp %h got %h", idx, key_reg[idx], prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      csr_access(1'b1, KEY_WORD0_IDX, k0);
      csr_access(1'b1, KEY_WORD1_IDX, k1);
      csr_access(1'b1, KEY_WORD2_IDX, k2);
      csr_access(1'b1, KEY_WORD3_IDX, k3);
   endtask

   task automatic check_keys();
      csr_access(1'b0, KEY_WORD0_IDX, '0);
      csr_access(1'b0, KEY_WORD1_IDX, '0);
      csr_access(1'b0, KEY_WORD2_IDX, '0);
      csr_access(1'b0, KEY_WORD3_IDX, '0);
   endtask

   task automatic send_buffer(input int len);
      for (int w = 0; w < len; w++) send_item(data_item(w == 0, $urandom, pick_count()));
   endtask

   // no keystream yet: words pass unchanged, starting without a first-word mark
   task automatic test_passthrough_before_rebuild();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      send_item(data_item(1'b0, 32'h0000_0000, 3'd4));
      send_item(data_item(1'b0, 32'hffff_ffff, 3'd4));
      for (int c = 0; c < 8; c++) send_item(data_item(1'b0, $urandom, 3'(c)));
      send_item(data_item(1'b1, 32'hffff_ffff, 3'd1));
   endtask

   task automatic test_register_access();
      wait_idle();
      check_keys();
      set_keys('1, '1, '1, '1);
      check_keys();
      set_keys(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
      check_keys();
   endtask

   // extreme keys; rebuild mid-buffer keeps the position; byte counts 0..7
   task automatic test_rebuild_extremes();
      wait_idle();
      set_keys('0, '0, '0, '0);
      send_item(rebuild_item());
      send_item(data_item(1'b1, 32'h0000_0000, 3'd4));
      send_item(data_item(1'b0, 32'hffff_ffff, 3'd4));
      for (int c = 0; c < 8; c++) send_item(data_item(1'b0, $urandom, 3'(c)));
      wait_idle();
      set_keys('1, '1, '1, '1);
      send_item(rebuild_item());
      send_item(data_item(1'b0, 32'h0000_0000, 3'd4));
      send_item(data_item(1'b0, $urandom, 3'd2));
      send_item(data_item(1'b1, $urandom, 3'd4));
   endtask

   // dense part runs out into the sparse strides, then a restart mid-sparse at full rate
   task automatic test_sparse_transition();
      wait_idle();
      set_keys($urandom, $urandom, $urandom, $urandom);
      check_keys();
      req_gap_pct = 15;
      rsp_stall_pct = 15;
      send_item(rebuild_item());
      send_buffer(DENSE_WORDS_DEF + 2);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      send_buffer(16);
   endtask

   task automatic test_random_traffic();
      kxd_req_type item;
      int len;
      int sent;
      int roll;
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            1: set_keys('1, '1, '1, '1);
            3: set_keys('0, '0, '0, '0);
            default: set_keys($urandom, $urandom, $urandom, $urandom);
         endcase
         check_keys();
         req_gap_pct = (phase == 3) ? 0 : 25;
         rsp_stall_pct = (phase == 3) ? 0 : 20;
         // phase 2 keeps the old table: new keys only matter at a rebuild
         if (phase != 2) send_item(rebuild_item());
         sent = 0;
         while (sent < 3) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 100) : $urandom_range(1, 40);
            for (int w = 0; w < len && sent < 3; w++) begin
               roll = $urandom_range(0, 199);
               if (roll < 2) item = rebuild_item();
               else if (roll < 24)
                  item = data_item(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
               else
                  item = data_item(w == 0, $urandom, pick_count());
               send_item(item);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_ready <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_passthrough_before_rebuild();
      test_register_access();
      test_rebuild_extremes();
      test_random_traffic();
      test_sparse_transition();

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run: %0d data words, %0d results, %0d keystream rebuilds, %0d key writes",
               data_words, result_count, rebuild_count, csr_writes);
      $display("keystream pointer wrapped %0d times; %0d failures", pad_wraps, mismatch_count);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
